### rtl/gpdc_pkg.sv
`default_nettype none
package gpdc_pkg;

  // Predictor geometry
  localparam int INDEX_BITS    = 16;
  localparam int SELECT_BITS   = 1;
  localparam int CACHE_ENTRIES = 64;
  localparam int BLOCK_ENTRIES = 512;

  localparam int PC_W      = 32;
  localparam int CTR_W     = 2;
  localparam int LIMIT_W   = 2;
  localparam int MCNT_W    = 2;
  localparam int SLOT_W    = $clog2(CACHE_ENTRIES);
  localparam int AGE_W     = $clog2(CACHE_ENTRIES);
  localparam int CTR_AW    = INDEX_BITS + SELECT_BITS;
  localparam int CTR_DEPTH = 2 ** CTR_AW;
  localparam int BLK_AW    = $clog2(BLOCK_ENTRIES);
  localparam int BLK_CW    = BLK_AW + 1;

  localparam logic [AGE_W-1:0]   AGE_MAX   = AGE_W'(CACHE_ENTRIES - 1);
  localparam logic [CTR_W-1:0]   CTR_MAX   = '1;
  localparam logic [MCNT_W-1:0]  MCNT_MAX  = '1;
  localparam logic [BLK_CW-1:0]  BLK_FULL  = BLK_CW'(BLOCK_ENTRIES);
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 2'd3;

  // Register map (word index)
  localparam logic REG_LIMIT = 1'b0;

  typedef enum logic {
    OP_PREDICT = 1'b0,
    OP_UPDATE  = 1'b1
  } op_t;

  typedef struct packed {
    op_t             op;
    logic [PC_W-1:0] pc;
    logic            taken;
    logic            pred;
  } item_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  // Back end status toward the front end
  typedef struct packed {
    logic pop;
    logic clearing;
  } back_status_t;

  typedef logic [CACHE_ENTRIES-1:0] slot_vec_t;

  // Isolate the lowest set bit
  function automatic slot_vec_t first_one(input slot_vec_t v);
    return v & (~v + slot_vec_t'(1));
  endfunction

  function automatic logic [SLOT_W-1:0] onehot_to_slot(input slot_vec_t v);
    logic [SLOT_W-1:0] s;
    s = '0;
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      if (v[i]) s = s | SLOT_W'(i);
    end
    return s;
  endfunction

endpackage
`default_nettype wire

### rtl/gpdc_ram.sv
`default_nettype none
module gpdc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire                     re,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/gpdc_front.sv
`default_nettype none
module gpdc_front
  import gpdc_pkg::*;
(
  input  wire          clk,
  input  wire          rst,
  input  wire          start,
  input  item_t        in_item,
  input  back_status_t status,
  output logic         busy,
  output queue_head_t  head
);

  // Two-entry queue between command port and back end
  item_t       slots [2];
  logic        rd_ptr;
  logic        wr_ptr;
  logic [1:0]  fill;
  logic        push;
  logic        pop;

  assign busy = (fill == 2'd2) || status.clearing;
  assign push = start && !busy;
  assign pop  = status.pop && (fill != 2'd0);

  assign head.valid = (fill != 2'd0);
  assign head.item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= in_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

### rtl/gpdc_back.sv
`default_nettype none
module gpdc_back
  import gpdc_pkg::*;
(
  input  wire                clk,
  input  wire                rst,
  input  queue_head_t        head,
  input  wire [LIMIT_W-1:0]  limit,
  output back_status_t       status,
  output logic               done,
  output logic               res_taken,
  output logic               res_hit
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_P_LOOK, S_P_RES, S_U_START,
    S_U_SCAN_RD, S_U_SCAN_CMP, S_U_MISS, S_U_HIT
  } state_t;

  state_t state;

  // Current item
  item_t cur;

  // Predictor state
  logic [INDEX_BITS-1:0]  history;
  logic [SELECT_BITS-1:0] tsel;
  logic [PC_W-1:0]        pcs   [CACHE_ENTRIES];
  logic                   dirs  [CACHE_ENTRIES];
  logic [AGE_W-1:0]       ages  [CACHE_ENTRIES];
  logic [MCNT_W-1:0]      mcnt  [CACHE_ENTRIES];
  logic                   last_hit;
  logic [SLOT_W-1:0]      last_slot;
  logic [BLK_CW-1:0]      blk_count;
  logic [BLK_AW-1:0]      blk_wptr;

  // Work registers
  slot_vec_t          match;
  logic [CTR_AW-1:0]  cs_reg;
  logic [CTR_AW-1:0]  clr_addr;
  logic [BLK_CW-1:0]  scan_idx;
  logic               blocked;

  // Memories
  logic               ctr_we;
  logic [CTR_AW-1:0]  ctr_waddr;
  logic [CTR_W-1:0]   ctr_wdata;
  logic               ctr_re;
  logic [CTR_W-1:0]   ctr_rdata;
  logic               blk_we;
  logic [BLK_AW-1:0]  blk_waddr;
  logic               blk_re;
  logic [PC_W-1:0]    blk_rdata;

  logic [CTR_AW-1:0]  cs;
  slot_vec_t          hit_oh;
  logic               hit_any;
  logic               hit_dir;
  slot_vec_t          empty_vec;
  slot_vec_t          aged_vec;
  slot_vec_t          ins_oh;
  logic               ins_ok;
  slot_vec_t          s_oh;
  logic [MCNT_W-1:0]  mc_s;
  logic [PC_W-1:0]    pc_s;
  logic [MCNT_W-1:0]  mc_new;
  logic [LIMIT_W-1:0] lim;
  logic               mis;
  logic               flush;
  logic [CTR_W-1:0]   ctr_new;
  logic [SELECT_BITS-1:0] tsel_next;

  assign cs = {tsel, cur.pc[INDEX_BITS-1:0] ^ history};

  // Predict resolve: first matching slot
  always_comb begin
    hit_oh  = first_one(match);
    hit_any = |match;
    hit_dir = 1'b0;
    for (int i = 0; i < CACHE_ENTRIES; i++) hit_dir = hit_dir | (hit_oh[i] & dirs[i]);
  end

  // Miss insertion: first empty slot, else first saturated age; none if blocked
  always_comb begin
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      empty_vec[i] = (pcs[i] == '0);
      aged_vec[i]  = (ages[i] == AGE_MAX);
    end
    ins_ok = ((|empty_vec) || (|aged_vec)) && !blocked;
    if (|empty_vec) ins_oh = first_one(empty_vec);
    else ins_oh = first_one(aged_vec);
    if (!ins_ok) ins_oh = '0;
  end

  // Hit update: read the slot left by the last predict
  always_comb begin
    s_oh = slot_vec_t'(1) << last_slot;
    mc_s = '0;
    pc_s = '0;
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      if (s_oh[i]) begin
        mc_s = mc_s | mcnt[i];
        pc_s = pc_s | pcs[i];
      end
    end
    mis    = (cur.taken != cur.pred);
    mc_new = (mc_s == MCNT_MAX) ? MCNT_MAX : mc_s + MCNT_W'(1);
    lim    = (limit == '0) ? LIMIT_W'(1) : limit;
    flush  = mis && (mc_new >= lim);
  end

  // Counter training
  always_comb begin
    if (cur.taken) ctr_new = (ctr_rdata == CTR_MAX) ? CTR_MAX : ctr_rdata + CTR_W'(1);
    else ctr_new = (ctr_rdata == '0) ? '0 : ctr_rdata - CTR_W'(1);
    tsel_next = (tsel >> 1) | (SELECT_BITS'(cur.taken) << (SELECT_BITS - 1));
  end

  // Memory ports
  always_comb begin
    ctr_we    = (state == S_CLEAR) || (state == S_U_MISS);
    ctr_waddr = (state == S_CLEAR) ? clr_addr : cs_reg;
    ctr_wdata = (state == S_CLEAR) ? '0 : ctr_new;
    ctr_re    = (state == S_P_LOOK) || (state == S_U_START);
    blk_we    = (state == S_U_HIT) && flush;
    blk_waddr = (blk_count < BLK_FULL) ? blk_count[BLK_AW-1:0] : blk_wptr;
    blk_re    = (state == S_U_SCAN_RD) && (scan_idx < blk_count);
  end

  gpdc_ram #(.WIDTH(CTR_W), .DEPTH(CTR_DEPTH)) u_ctr_ram (
    .clk(clk), .we(ctr_we), .waddr(ctr_waddr), .wdata(ctr_wdata),
    .re(ctr_re), .raddr(cs), .rdata(ctr_rdata)
  );

  gpdc_ram #(.WIDTH(PC_W), .DEPTH(BLOCK_ENTRIES)) u_blk_ram (
    .clk(clk), .we(blk_we), .waddr(blk_waddr), .wdata(pc_s),
    .re(blk_re), .raddr(scan_idx[BLK_AW-1:0]), .rdata(blk_rdata)
  );

  assign status.pop      = (state == S_IDLE);
  assign status.clearing = (state == S_CLEAR);

  // Sequencer, predictor state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      history   <= '0;
      tsel      <= '1;
      last_hit  <= 1'b0;
      last_slot <= '0;
      blk_count <= '0;
      blk_wptr  <= '0;
      done      <= 1'b0;
      res_taken <= 1'b0;
      res_hit   <= 1'b0;
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
        pcs[i]  <= '0;
        dirs[i] <= 1'b0;
        ages[i] <= '0;
        mcnt[i] <= '0;
      end
    end else begin
      done      <= 1'b0;
      res_taken <= 1'b0;
      res_hit   <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + CTR_AW'(1);
          if (clr_addr == '1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (head.valid) begin
            cur   <= head.item;
            state <= (head.item.op == OP_UPDATE) ? S_U_START : S_P_LOOK;
          end
        end
        S_P_LOOK: begin
          for (int i = 0; i < CACHE_ENTRIES; i++) match[i] <= (pcs[i] == cur.pc);
          state <= S_P_RES;
        end
        S_P_RES: begin
          last_hit  <= hit_any;
          if (hit_any) last_slot <= onehot_to_slot(hit_oh);
          done      <= 1'b1;
          res_hit   <= hit_any;
          res_taken <= hit_any ? hit_dir : ctr_rdata[1];
          state     <= S_IDLE;
        end
        S_U_START: begin
          cs_reg   <= cs;
          scan_idx <= '0;
          blocked  <= 1'b0;
          state    <= last_hit ? S_U_HIT : S_U_SCAN_RD;
        end
        S_U_SCAN_RD: begin
          state <= (scan_idx < blk_count) ? S_U_SCAN_CMP : S_U_MISS;
        end
        S_U_SCAN_CMP: begin
          if (blk_rdata == cur.pc) begin
            blocked <= 1'b1;
            state   <= S_U_MISS;
          end else begin
            scan_idx <= scan_idx + BLK_CW'(1);
            state    <= S_U_SCAN_RD;
          end
        end
        S_U_MISS: begin
          for (int i = 0; i < CACHE_ENTRIES; i++) begin
            if (ins_oh[i]) begin
              pcs[i]  <= cur.pc;
              dirs[i] <= cur.taken;
              ages[i] <= AGE_W'(1);
            end else if (ages[i] != AGE_MAX) begin
              ages[i] <= ages[i] + AGE_W'(1);
            end
          end
          history <= {history[INDEX_BITS-2:0], cur.taken};
          tsel    <= tsel_next;
          done    <= 1'b1;
          state   <= S_IDLE;
        end
        S_U_HIT: begin
          for (int i = 0; i < CACHE_ENTRIES; i++) begin
            if (s_oh[i] && (!mis || flush)) begin
              ages[i] <= AGE_W'(1);
            end else if (ages[i] != AGE_MAX) begin
              ages[i] <= ages[i] + AGE_W'(1);
            end
            if (s_oh[i] && mis) begin
              mcnt[i] <= flush ? '0 : mc_new;
              dirs[i] <= flush ? 1'b0 : cur.taken;
              if (flush) pcs[i] <= '0;
            end
          end
          if (flush) begin
            if (blk_count < BLK_FULL) blk_count <= blk_count + BLK_CW'(1);
            else blk_wptr <= blk_wptr + BLK_AW'(1);
          end
          history <= {history[INDEX_BITS-2:0], cur.taken};
          done    <= 1'b1;
          state   <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/gshare_predictor_with_direction_cache.sv
// Gshare branch direction predictor with a 64-entry fully associative
// direction cache. Pulse start while busy is low to hand over an item; each
// item yields one result on predict_taken/cache_hit, marked by a one-cycle
// done pulse that cannot be held off. After reset the block sweeps its
// 131072-entry counter table to zero, one entry a cycle, and holds busy high
// throughout the sweep. A two-entry queue takes items while earlier ones
// execute. A predict passes from queue to result through a cache compare,
// then a priority select with the counter read. An update that hit runs a
// start step and a hit step; one that missed scans the listed entries of the
// 512-entry blocked list, a read step and a compare step per entry through
// its single read port, cut short when the pc is found.
`default_nettype none
module gshare_predictor_with_direction_cache
  import gpdc_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  output logic        busy,
  output logic        done,
  input  wire         operation,
  input  wire  [31:0] pc,
  input  wire         resolved_taken,
  input  wire         predicted_taken,
  output logic        predict_taken,
  output logic        cache_hit,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [LIMIT_W-1:0] limit;
  item_t              in_item;
  queue_head_t        head;
  back_status_t       status;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LIMIT) ? 32'(limit) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RST;
    end else if (psel && penable && pwrite && paddr[2] == REG_LIMIT) begin
      limit <= pwdata[LIMIT_W-1:0];
    end
  end

  assign in_item.op    = op_t'(operation);
  assign in_item.pc    = pc;
  assign in_item.taken = resolved_taken;
  assign in_item.pred  = predicted_taken;

  gpdc_front u_front (
    .clk(clk), .rst(rst), .start(start), .in_item(in_item),
    .status(status), .busy(busy), .head(head)
  );

  gpdc_back u_back (
    .clk(clk), .rst(rst), .head(head), .limit(limit), .status(status),
    .done(done), .res_taken(predict_taken), .res_hit(cache_hit)
  );

endmodule
`default_nettype wire

### rtl/gpdc_checker.sv
`default_nettype none
module gpdc_checker (
  input wire clk,
  input wire rst,
  input wire busy,
  input wire done,
  input wire predict_taken,
  input wire cache_hit
);

  // Counter sweep holds off commands right after reset
  a_busy_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> busy) else $error("not busy after reset");

  a_no_done_after_reset: assert property (@(posedge clk)
    rst |=> !done) else $error("result right after reset");

  // Done pulses are never back to back
  a_done_spaced: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("back-to-back results");

  a_quiet_outputs: assert property (@(posedge clk) disable iff (rst)
    !done |-> (!predict_taken && !cache_hit)) else $error("result bits without done");

endmodule

bind gshare_predictor_with_direction_cache gpdc_checker u_gpdc_checker (
  .clk(clk), .rst(rst), .busy(busy), .done(done),
  .predict_taken(predict_taken), .cache_hit(cache_hit)
);
`default_nettype wire
